FILE: design/sws_pkg.sv
package sws_pkg;

  // Store geometry and fraction width of the read position
  localparam int unsigned DELAY_DEPTH = 4096;  // power of two
  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned ADDR_W      = $clog2(DELAY_DEPTH);
  localparam int unsigned POS_W       = ADDR_W + FRAC_BITS;

  // Field and register widths
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned DLEN_W     = 20;
  localparam int unsigned DAMP_W     = 16;
  localparam int unsigned STIFF_W    = 15;
  localparam int unsigned OFFS_W     = 12;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  // Width for clamping the delay length
  localparam int unsigned CMP_W = (POS_W > DLEN_W) ? POS_W : DLEN_W;

  // Shared multiplier operand widths
  localparam int unsigned MA_W      = SAMPLE_W + 1;
  localparam int unsigned COEF_W    = 17;
  localparam int unsigned PROD_W    = MA_W + COEF_W;
  localparam int unsigned Q15_SHIFT = 15;

  // Opcodes
  localparam logic [OP_W-1:0] OP_PROCESS = OP_W'(0);
  localparam logic [OP_W-1:0] OP_CLEAR   = OP_W'(1);
  localparam logic [OP_W-1:0] OP_LOAD    = OP_W'(2);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING_COEF   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS_COEF = CFG_IDX_W'(2);

  // Register reset values and limits
  localparam logic [DLEN_W-1:0]  DLEN_RESET = DLEN_W'(27927);
  localparam logic [CMP_W-1:0]   DLEN_MIN   = CMP_W'(longint'(10) << FRAC_BITS);
  localparam logic [CMP_W-1:0]   DLEN_MAX   = CMP_W'(longint'(DELAY_DEPTH - 1) << FRAC_BITS);
  localparam logic [COEF_W-1:0]  Q15_ONE    = COEF_W'(32768);
  localparam logic [COEF_W-1:0]  FB_GAIN    = COEF_W'(32604);

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_I_MUL,
    S_I_ADD,
    S_L_MUL,
    S_L_ADD,
    S_A_MUL,
    S_A_ADD,
    S_B_MUL,
    S_B_ADD,
    S_W_MUL,
    S_W_ADD,
    S_RESULT
  } seq_state_e;

  typedef struct packed {
    logic [DLEN_W-1:0]  delay_length;
    logic [DAMP_W-1:0]  damping_coef;
    logic [STIFF_W-1:0] stiffness_coef;
  } cfg_t;

  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [SAMPLE_W-1:0] wdata;
    logic                re;
    logic [ADDR_W-1:0]   raddr0;
    logic [ADDR_W-1:0]   raddr1;
  } ram_req_t;

  // result = sat(base + round(a * c >> shift)), shift is FRAC_BITS or 15
  typedef struct packed {
    logic [MA_W-1:0]     a;
    logic [COEF_W-1:0]   c;
    logic [SAMPLE_W-1:0] base;
    logic                frac_shift;
  } mac_op_t;

endpackage

FILE: design/string_waveguide_resonator.sv
// Plucked-string waveguide with one shared multiply-round-saturate unit under a
// sequencer. After reset, and for every clear transaction, a clearing pass
// zeroes the 4096-entry delay store, during which no input is taken
// (configuration writes are). A process transaction reads the store, then
// uses the shared unit for three multiplies when stiffness_coef is zero,
// five otherwise, each in a multiply state and an add state, then offers
// its result; no new input is taken until that result is handed over.
// Load and unused opcodes go straight to the result; clear clears first. Each input
// transaction gives exactly one result transaction, zero for all but process.
// The output register lets a new input be taken while a result waits.
module string_waveguide_resonator import sws_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [OP_W-1:0]       opcode_i,
  input  logic [SAMPLE_W-1:0]   sample_in_i,
  input  logic [OFFS_W-1:0]     load_offset_i,
  // Output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SAMPLE_W-1:0]   sample_out_o,
  // Configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t                cfg_q;
  ram_req_t            ram_req;
  logic [SAMPLE_W-1:0] rdata0;
  logic [SAMPLE_W-1:0] rdata1;
  logic                mac_en;
  mac_op_t             mac_op;
  logic [SAMPLE_W-1:0] mac_result;
  logic                res_valid;
  logic                res_ready;
  logic [SAMPLE_W-1:0] res_data;
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] sample_out_q;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay_length   <= DLEN_RESET;
      cfg_q.damping_coef   <= '0;
      cfg_q.stiffness_coef <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DELAY_LENGTH:   cfg_q.delay_length   <= cfg_data_i[DLEN_W-1:0];
        CFG_DAMPING_COEF:   cfg_q.damping_coef   <= cfg_data_i[DAMP_W-1:0];
        CFG_STIFFNESS_COEF: cfg_q.stiffness_coef <= cfg_data_i[STIFF_W-1:0];
        default: ;
      endcase
    end
  end

  sws_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .sample_in_i   (sample_in_i),
    .load_offset_i (load_offset_i),
    .ram_req_o     (ram_req),
    .rdata0_i      (rdata0),
    .rdata1_i      (rdata1),
    .mac_en_o      (mac_en),
    .mac_op_o      (mac_op),
    .mac_result_i  (mac_result),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_data_o    (res_data)
  );

  sws_delay_ram u_ram (
    .clk_i    (clk_i),
    .req_i    (ram_req),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  sws_mac u_mac (
    .clk_i    (clk_i),
    .en_i     (mac_en),
    .op_i     (mac_op),
    .result_o (mac_result)
  );

  // Output register
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      sample_out_q <= res_data;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;

  // A handed-over result lands in the output register unchanged
  a_result_handover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> (out_valid_q && (sample_out_q == $past(res_data))))
    else $error("result lost at output register");

endmodule

FILE: design/sws_delay_ram.sv
module sws_delay_ram import sws_pkg::*; (
  input  logic                clk_i,
  input  ram_req_t            req_i,
  output logic [SAMPLE_W-1:0] rdata0_o,
  output logic [SAMPLE_W-1:0] rdata1_o
);

  logic [SAMPLE_W-1:0] mem [DELAY_DEPTH];

  // One write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Two registered read ports for the interpolation pair
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata0_o <= mem[req_i.raddr0];
      rdata1_o <= mem[req_i.raddr1];
    end
  end

endmodule

FILE: design/sws_mac.sv
module sws_mac import sws_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  mac_op_t             op_i,
  output logic [SAMPLE_W-1:0] result_o
);

  localparam int unsigned SUM_W = PROD_W + 1;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

  logic signed [PROD_W-1:0] prod_q;
  logic [SAMPLE_W-1:0]      base_q;
  logic                     frac_q;

  logic [PROD_W-1:0]        rnd;
  logic signed [PROD_W-1:0] rounded;
  logic signed [PROD_W-1:0] shifted;
  logic signed [SUM_W-1:0]  sum;

  // Multiply stage, product registered
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= $signed(op_i.a) * $signed(op_i.c);
      base_q <= op_i.base;
      frac_q <= op_i.frac_shift;
    end
  end

  // Round half up, arithmetic shift, add base, saturate to 24 bits
  always_comb begin
    rnd     = frac_q ? (PROD_W'(1) << (FRAC_BITS - 1)) : (PROD_W'(1) << (Q15_SHIFT - 1));
    rounded = prod_q + $signed(rnd);
    shifted = frac_q ? (rounded >>> FRAC_BITS) : (rounded >>> Q15_SHIFT);
    sum     = $signed({shifted[PROD_W-1], shifted}) +
              $signed({{(SUM_W-SAMPLE_W){base_q[SAMPLE_W-1]}}, base_q});
    if (sum > SAT_HI) begin
      result_o = SAT_HI[SAMPLE_W-1:0];
    end else if (sum < SAT_LO) begin
      result_o = SAT_LO[SAMPLE_W-1:0];
    end else begin
      result_o = sum[SAMPLE_W-1:0];
    end
  end

endmodule

FILE: design/sws_seq.sv
module sws_seq import sws_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OP_W-1:0]     opcode_i,
  input  logic [SAMPLE_W-1:0] sample_in_i,
  input  logic [OFFS_W-1:0]   load_offset_i,
  output ram_req_t            ram_req_o,
  input  logic [SAMPLE_W-1:0] rdata0_i,
  input  logic [SAMPLE_W-1:0] rdata1_i,
  output logic                mac_en_o,
  output mac_op_t             mac_op_o,
  input  logic [SAMPLE_W-1:0] mac_result_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output logic [SAMPLE_W-1:0] res_data_o
);

  seq_state_e state_q, state_d;

  logic [ADDR_W-1:0]   clr_cnt_q;
  logic                reply_q;
  logic [ADDR_W-1:0]   wp_q;
  logic [SAMPLE_W-1:0] lp_q;
  logic [SAMPLE_W-1:0] ap_q;
  logic [SAMPLE_W-1:0] v_q;
  logic [SAMPLE_W-1:0] y_q;
  logic [SAMPLE_W-1:0] t_q;
  logic [SAMPLE_W-1:0] x_q;
  logic [SAMPLE_W-1:0] res_q;

  logic                in_acc;
  logic [CMP_W-1:0]    dl_ext;
  logic [CMP_W-1:0]    dl_clamp;
  logic [POS_W-1:0]    rd_pos;
  logic [FRAC_BITS-1:0] frac;
  logic [COEF_W-1:0]   damp;
  logic [COEF_W-1:0]   stiff;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign res_valid_o = (state_q == S_RESULT);
  assign res_data_o  = res_q;

  // Read position: clamped delay behind the write pointer, wraps naturally
  always_comb begin
    dl_ext = CMP_W'(cfg_i.delay_length);
    if (dl_ext < DLEN_MIN) begin
      dl_clamp = DLEN_MIN;
    end else if (dl_ext > DLEN_MAX) begin
      dl_clamp = DLEN_MAX;
    end else begin
      dl_clamp = dl_ext;
    end
    rd_pos = {wp_q, {FRAC_BITS{1'b0}}} - dl_clamp[POS_W-1:0];
    frac   = rd_pos[FRAC_BITS-1:0];
  end

  // Coefficients; damping above one acts as one
  assign damp  = (COEF_W'(cfg_i.damping_coef) > Q15_ONE) ? Q15_ONE
                                                          : COEF_W'(cfg_i.damping_coef);
  assign stiff = COEF_W'(cfg_i.stiffness_coef);

  // Next state, memory and multiplier requests
  always_comb begin
    state_d              = state_q;
    ram_req_o            = '0;
    ram_req_o.raddr0     = rd_pos[POS_W-1:FRAC_BITS];
    ram_req_o.raddr1     = rd_pos[POS_W-1:FRAC_BITS] + ADDR_W'(1);
    mac_en_o             = 1'b0;
    mac_op_o             = '0;
    case (state_q)
      S_CLR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = clr_cnt_q;
        ram_req_o.wdata = '0;
        if (clr_cnt_q == ADDR_W'(DELAY_DEPTH - 1)) begin
          state_d = reply_q ? S_RESULT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          case (opcode_i)
            OP_PROCESS: begin
              ram_req_o.re = 1'b1;
              state_d      = S_I_MUL;
            end
            OP_CLEAR: begin
              state_d = S_CLR;
            end
            OP_LOAD: begin
              ram_req_o.we    = 1'b1;
              ram_req_o.waddr = wp_q + ADDR_W'(load_offset_i);
              ram_req_o.wdata = sample_in_i;
              state_d         = S_RESULT;
            end
            default: begin
              state_d = S_RESULT;
            end
          endcase
        end
      end
      // Interpolation: s0 + round((s1 - s0) * f)
      S_I_MUL: begin
        mac_en_o            = 1'b1;
        mac_op_o.a          = {rdata1_i[SAMPLE_W-1], rdata1_i} -
                              {rdata0_i[SAMPLE_W-1], rdata0_i};
        mac_op_o.c          = COEF_W'(frac);
        mac_op_o.base       = rdata0_i;
        mac_op_o.frac_shift = 1'b1;
        state_d             = S_I_ADD;
      end
      S_I_ADD: state_d = S_L_MUL;
      // One-pole lowpass
      S_L_MUL: begin
        mac_en_o      = 1'b1;
        mac_op_o.a    = {v_q[SAMPLE_W-1], v_q} - {lp_q[SAMPLE_W-1], lp_q};
        mac_op_o.c    = damp;
        mac_op_o.base = lp_q;
        state_d       = S_L_ADD;
      end
      S_L_ADD: state_d = (cfg_i.stiffness_coef != '0) ? S_A_MUL : S_W_MUL;
      // Allpass output: state - k * y
      S_A_MUL: begin
        mac_en_o      = 1'b1;
        mac_op_o.a    = {y_q[SAMPLE_W-1], y_q};
        mac_op_o.c    = -stiff;
        mac_op_o.base = ap_q;
        state_d       = S_A_ADD;
      end
      S_A_ADD: state_d = S_B_MUL;
      // Allpass state: y + k * ap
      S_B_MUL: begin
        mac_en_o      = 1'b1;
        mac_op_o.a    = {t_q[SAMPLE_W-1], t_q};
        mac_op_o.c    = stiff;
        mac_op_o.base = y_q;
        state_d       = S_B_ADD;
      end
      S_B_ADD: state_d = S_W_MUL;
      // Feedback: excitation + 0.995 * y
      S_W_MUL: begin
        mac_en_o      = 1'b1;
        mac_op_o.a    = {y_q[SAMPLE_W-1], y_q};
        mac_op_o.c    = FB_GAIN;
        mac_op_o.base = x_q;
        state_d       = S_W_ADD;
      end
      S_W_ADD: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = wp_q;
        ram_req_o.wdata = mac_result_i;
        state_d         = S_RESULT;
      end
      S_RESULT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and string state; reset runs a clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_cnt_q <= '0;
      reply_q   <= 1'b0;
      wp_q      <= '0;
      lp_q      <= '0;
      ap_q      <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (in_acc && (opcode_i == OP_CLEAR)) begin
            clr_cnt_q <= '0;
            reply_q   <= 1'b1;
          end
        end
        S_CLR: begin
          clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
          wp_q      <= '0;
          lp_q      <= '0;
          ap_q      <= '0;
        end
        S_L_ADD: lp_q <= mac_result_i;
        S_B_ADD: ap_q <= mac_result_i;
        S_W_ADD: wp_q <= wp_q + ADDR_W'(1);
        default: ;
      endcase
    end
  end

  // Working values
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          x_q   <= sample_in_i;
          res_q <= '0;
        end
      end
      S_I_ADD: v_q   <= mac_result_i;
      S_L_ADD: y_q   <= mac_result_i;
      S_A_ADD: t_q   <= mac_result_i;
      S_B_ADD: y_q   <= t_q;
      S_W_ADD: res_q <= y_q;
      default: ;
    endcase
  end

  // Clearing pass writes zeros every cycle
  a_clr_writes_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> (ram_req_o.we && (ram_req_o.wdata == '0)))
    else $error("clearing pass not writing zero");

  // Pointer moves by one after each writeback
  a_wp_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_W_ADD) |=> (wp_q == $past(wp_q) + ADDR_W'(1)))
    else $error("write pointer did not advance");

  // Lowpass state only changes in its update step or on clear
  a_lp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((state_q == S_L_ADD) || (state_q == S_CLR)) |=> $stable(lp_q))
    else $error("lowpass state changed unexpectedly");

endmodule

FILE: test/tb_string_waveguide_resonator.sv
module tb_string_waveguide_resonator;
  import sws_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [OP_W-1:0]      OP_UNUSED = OP_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

  localparam logic [SAMPLE_W-1:0] PEAK_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] PEAK_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam longint SAT_HI = 8388607;
  localparam longint SAT_LO = -8388608;

  localparam int RAND_PHASES    = 10;
  localparam int PHASE_ITEMS    = 80;
  localparam int QUIET_PHASES   = 2;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int TAIL_CYCLES    = 50;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [OP_W-1:0]        op;
    logic [SAMPLE_W-1:0]    sample;
    logic [OFFS_W-1:0]      offset;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_data;
    bit                     typed;
    logic [SAMPLE_W-1:0]    want;
  } script_row_t;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic [OP_W-1:0]       opcode_i      = '0;
  logic [SAMPLE_W-1:0]   sample_in_i   = '0;
  logic [OFFS_W-1:0]     load_offset_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic [SAMPLE_W-1:0]   sample_out_o;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // String model state and its copy of the registers
  logic signed [SAMPLE_W-1:0] string_store [DELAY_DEPTH];
  logic [ADDR_W-1:0]          write_pos   = '0;
  longint                     lowpass_acc = 0;
  longint                     allpass_acc = 0;
  logic [DLEN_W-1:0]          reg_delay   = DLEN_RESET;
  logic [DAMP_W-1:0]          reg_damp    = '0;
  logic [STIFF_W-1:0]         reg_stiff   = '0;

  logic [SAMPLE_W-1:0] pending_samples[$];

  int  mismatches      = 0;
  int  results_checked = 0;
  int  reg_writes      = 0;
  int  op_count[4]     = '{0, 0, 0, 0};
  int  idle_cycles     = 0;
  int  stall_left      = 0;
  int  gap_pct         = 0;
  int  stall_pct       = 0;
  bit  quiet           = 1'b0;

  string_waveguide_resonator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .sample_in_i   (sample_in_i),
    .load_offset_i (load_offset_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_out_o  (sample_out_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic longint sat24(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // Q1.15 product, rounded half up (>>> floors on signed)
  function automatic longint mul_q15(longint a, longint c);
    return (a * c + 16384) >>> 15;
  endfunction

  // Advances the string model by one input transaction, returns its sample_out
  function automatic logic [SAMPLE_W-1:0] next_string_sample(logic [OP_W-1:0] op,
                                                             logic [SAMPLE_W-1:0] x_raw,
                                                             logic [OFFS_W-1:0] off);
    longint x, d, rp, f, s0, s1, v, damp, k, y, ap;
    int unsigned i0, i1;
    logic [ADDR_W-1:0] slot;
    x = longint'($signed(x_raw));
    y = 0;
    case (op)
      OP_PROCESS: begin
        // fractional read behind the pointer, delay clamped to 10 .. depth-1
        d = longint'(reg_delay);
        if (d < longint'(DLEN_MIN)) d = longint'(DLEN_MIN);
        if (d > longint'(DLEN_MAX)) d = longint'(DLEN_MAX);
        rp = (longint'(write_pos) << FRAC_BITS) - d;
        if (rp < 0) rp += longint'(DELAY_DEPTH) << FRAC_BITS;
        i0 = 32'((rp >> FRAC_BITS) % DELAY_DEPTH);
        i1 = (i0 + 1) % DELAY_DEPTH;
        f  = rp & ((1 << FRAC_BITS) - 1);
        s0 = longint'(string_store[i0]);
        s1 = longint'(string_store[i1]);
        v  = sat24((s0 * ((1 << FRAC_BITS) - f) + s1 * f + (1 << (FRAC_BITS - 1)))
                   >>> FRAC_BITS);
        // one-pole damping; coefficients above one act as one
        damp = (reg_damp > Q15_ONE) ? longint'(Q15_ONE) : longint'(reg_damp);
        lowpass_acc = sat24(lowpass_acc + mul_q15(v - lowpass_acc, damp));
        y = lowpass_acc;
        // dispersion allpass, bypassed at zero stiffness
        if (reg_stiff != 0) begin
          k  = longint'(reg_stiff);
          ap = sat24(mul_q15(-k, y) + allpass_acc);
          allpass_acc = sat24(y + mul_q15(k, ap));
          y = ap;
        end
        string_store[write_pos] = SAMPLE_W'(sat24(mul_q15(y, longint'(FB_GAIN)) + x));
        write_pos = write_pos + 1'b1;
      end
      OP_CLEAR: begin
        foreach (string_store[i]) string_store[i] = '0;
        write_pos   = '0;
        lowpass_acc = 0;
        allpass_acc = 0;
      end
      OP_LOAD: begin
        slot = write_pos + off;
        string_store[slot] = x_raw;
      end
      default: ;
    endcase
    return y[SAMPLE_W-1:0];
  endfunction

  function automatic script_row_t item_row(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] x,
                                           logic [OFFS_W-1:0] off, bit typed,
                                           logic [SAMPLE_W-1:0] want);
    script_row_t r;
    r = '{ROW_ITEM, op, x, off, '0, '0, typed, want};
    return r;
  endfunction

  function automatic script_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
    script_row_t r;
    r = '{ROW_CFG, OP_PROCESS, '0, '0, idx, data, 1'b0, '0};
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [SAMPLE_W-1:0] want,
                                 logic [SAMPLE_W-1:0] got);
    $display("MISMATCH %s: expected %0d, got %0d at %0t",
             what, $signed(want), $signed(got), $time);
    mismatches++;
  endtask

  // One input transaction, with an optional idle burst in front
  task automatic send_item(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] x,
                           logic [OFFS_W-1:0] off, bit typed, logic [SAMPLE_W-1:0] want);
    logic [SAMPLE_W-1:0] got;
    cfg_valid_i <= 1'b0;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    sample_in_i   <= x;
    load_offset_i <= off;
    do @(posedge clk_i); while (in_stall_o);
    got = next_string_sample(op, x, off);
    pending_samples.push_back(typed ? want : got);
    op_count[op]++;
  endtask

  // Register write, only once every pending result has come back
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_DELAY_LENGTH:   reg_delay = data[DLEN_W-1:0];
      CFG_DAMPING_COEF:   reg_damp  = data[DAMP_W-1:0];
      CFG_STIFFNESS_COEF: reg_stiff = data[STIFF_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Result checking and output back-pressure
  always @(posedge clk_i) begin : result_side
    logic [SAMPLE_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("sample_out with nothing pending", 'x, sample_out_o);
      end else begin
        want = pending_samples.pop_front();
        results_checked++;
        if (sample_out_o !== want) report_mismatch("sample_out", want, sample_out_o);
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 5);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog: cycles in which no channel moves a transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    script_row_t script[$];
    logic [CFG_DATA_W-1:0] dl, dm, st;
    logic [DLEN_W-1:0]     dl_eff;
    logic [OP_W-1:0]       op;
    logic [SAMPLE_W-1:0]   x;
    int d_int, n_loads, sent;

    foreach (string_store[i]) string_store[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: reset settings first, damping zero keeps the string silent
    script.push_back(item_row(OP_PROCESS, '0, '0, 1'b1, '0));
    script.push_back(item_row(OP_UNUSED, PEAK_POS, '1, 1'b1, '0));
    script.push_back(item_row(OP_LOAD, PEAK_POS, '1, 1'b1, '0));
    script.push_back(item_row(OP_PROCESS, PEAK_NEG, '0, 1'b1, '0));
    script.push_back(item_row(OP_CLEAR, PEAK_NEG, '1, 1'b1, '0));
    // shortest delay, full-pass lowpass: reads come back exactly as loaded
    script.push_back(cfg_row(CFG_DELAY_LENGTH, CFG_DATA_W'(DLEN_MIN)));
    script.push_back(cfg_row(CFG_DAMPING_COEF, CFG_DATA_W'(Q15_ONE)));
    script.push_back(cfg_row(CFG_STIFFNESS_COEF, '0));
    script.push_back(item_row(OP_LOAD, PEAK_POS, OFFS_W'(DELAY_DEPTH - 10), 1'b1, '0));
    script.push_back(item_row(OP_LOAD, PEAK_NEG, OFFS_W'(DELAY_DEPTH - 9), 1'b1, '0));
    script.push_back(item_row(OP_PROCESS, '0, '0, 1'b1, PEAK_POS));
    script.push_back(item_row(OP_PROCESS, '0, '0, 1'b1, PEAK_NEG));
    script.push_back(item_row(OP_PROCESS, PEAK_POS, '0, 1'b1, '0));
    // delay below and above the clamp range
    script.push_back(cfg_row(CFG_DELAY_LENGTH, '0));
    script.push_back(item_row(OP_PROCESS, PEAK_POS, '0, 1'b0, '0));
    script.push_back(cfg_row(CFG_DELAY_LENGTH, '1));
    script.push_back(item_row(OP_PROCESS, '0, '0, 1'b0, '0));
    // damping above one, strongest dispersion
    script.push_back(cfg_row(CFG_DAMPING_COEF, '1));
    script.push_back(cfg_row(CFG_STIFFNESS_COEF, '1));
    script.push_back(item_row(OP_PROCESS, PEAK_NEG, '0, 1'b0, '0));
    script.push_back(item_row(OP_PROCESS, '0, '0, 1'b0, '0));
    script.push_back(cfg_row(CFG_SPARE, '1));
    script.push_back(item_row(OP_LOAD, PEAK_NEG, '0, 1'b1, '0));
    script.push_back(item_row(OP_CLEAR, '0, '0, 1'b1, '0));
    script.push_back(item_row(OP_PROCESS, PEAK_POS, '0, 1'b0, '0));

    foreach (script[r]) begin
      if (script[r].kind == ROW_CFG) write_reg(script[r].reg_idx, script[r].reg_data);
      else send_item(script[r].op, script[r].sample, script[r].offset,
                     script[r].typed, script[r].want);
    end

    // Random part: one setting per phase, a pluck, then the string rings
    for (int p = 0; p < RAND_PHASES; p++) begin
      quiet     = (p >= RAND_PHASES - QUIET_PHASES);
      gap_pct   = 25 * $urandom_range(0, 2);
      stall_pct = 25 * $urandom_range(0, 2);
      case (p)
        0: begin
          dl = CFG_DATA_W'(DLEN_MIN);
          dm = CFG_DATA_W'(Q15_ONE);
          st = {5'($urandom), 15'h7FFF};
        end
        1: begin
          dl = '1;
          dm = '0;
          st = CFG_DATA_W'(1);
        end
        2: begin
          dl = CFG_DATA_W'(DLEN_MAX);
          dm = '1;
          st = {5'h1F, 15'h0};
        end
        default: begin
          dl = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                           : CFG_DATA_W'($urandom_range(2560, 40000));
          dm = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                           : {4'($urandom), 16'($urandom_range(16384, 32768))};
          st = ($urandom_range(0, 1) == 0) ? {5'($urandom), 15'h0}
                                           : {5'($urandom), 15'($urandom_range(1, 32767))};
        end
      endcase
      write_reg(CFG_DELAY_LENGTH, dl);
      write_reg(CFG_DAMPING_COEF, dm);
      write_reg(CFG_STIFFNESS_COEF, st);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));

      sent = 0;
      if ($urandom_range(0, 3) == 0) begin
        send_item(OP_CLEAR, SAMPLE_W'($urandom), OFFS_W'($urandom), 1'b0, '0);
        sent++;
      end
      // pluck: fill the entries the next reads will reach
      dl_eff = (reg_delay < DLEN_MIN) ? DLEN_W'(DLEN_MIN) :
               (reg_delay > DLEN_MAX) ? DLEN_W'(DLEN_MAX) : reg_delay;
      d_int   = int'(dl_eff >> FRAC_BITS);
      n_loads = $urandom_range(8, 24);
      for (int t = 0; t < n_loads; t++) begin
        x = ($urandom_range(0, 1) == 0) ? SAMPLE_W'($urandom)
                                        : SAMPLE_W'($urandom_range(0, 2**21) - 2**20);
        send_item(OP_LOAD, x, OFFS_W'(DELAY_DEPTH - d_int + t), 1'b0, '0);
        sent++;
      end
      // ringing with sparse excitation, some noise transactions mixed in
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          op = OP_W'($urandom);
          if (op == OP_CLEAR && $urandom_range(0, 7) != 0) op = OP_UNUSED;
          send_item(op, SAMPLE_W'($urandom), OFFS_W'($urandom), 1'b0, '0);
        end else begin
          case ($urandom_range(0, 7))
            0:       x = SAMPLE_W'($urandom);
            1:       x = SAMPLE_W'($urandom_range(0, 2**21) - 2**20);
            default: x = '0;
          endcase
          send_item(OP_PROCESS, x, OFFS_W'($urandom), 1'b0, '0);
        end
        sent++;
      end
    end

    // Drain, then let any stray result show up
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d process, %0d load, %0d clear and %0d unused-opcode transactions",
             op_count[OP_PROCESS], op_count[OP_LOAD], op_count[OP_CLEAR], op_count[OP_UNUSED]);
    $display("Compared %0d output samples across %0d register writes, %0d mismatches",
             results_checked, reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: string_waveguide_resonator.f
design/sws_pkg.sv
design/sws_delay_ram.sv
design/sws_mac.sv
design/sws_seq.sv
design/string_waveguide_resonator.sv
test/tb_string_waveguide_resonator.sv
